// ===== rtl/core/iuts_pkg.sv =====
package iuts_pkg;

   // payload widths
   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 32;

   // default width of the number accumulator
   localparam int NUMBER_BITS_DEF = 32;

   // characters of interest
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2d;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2e;
   localparam logic [BYTE_W-1:0] CHAR_UNDER = 8'h5f;
   localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [BYTE_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LO_Z  = 8'h7a;
   localparam logic [BYTE_W-1:0] CHAR_LO_U  = 8'h75;
   localparam logic [BYTE_W-1:0] CHAR_LO_I  = 8'h69;
   localparam logic [BYTE_W-1:0] CHAR_LO_D  = 8'h64;

endpackage

// ===== rtl/core/iuts_req_if.sv =====
interface iuts_req_if
   import iuts_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/iuts_rsp_if.sv =====
interface iuts_rsp_if
   import iuts_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               uid_found;
   logic [VALUE_W-1:0] uid_value;

   modport source (output valid, output uid_found, output uid_value, input ready);
   modport sink   (input valid, input uid_found, input uid_value, output ready);
endinterface

// ===== rtl/core/imap_uid_token_scanner_core.sv =====
// imap uid token scanner
// req_chan carries the octets of one response line, one item per octet, with
// last_byte set on the final octet. rsp_chan returns one item per line, taken
// from the octet marked last: uid_found and the first whole-word UID number
// (low 32 bits), zero when none was found.
// throughput: one octet per cycle. the scan state (phase, boundary flag, number
// accumulator) is updated by a small state machine and a
// multiply-by-ten add on the NUMBER_BITS accumulator.
// latency: the result item is valid in the cycle after the last octet is taken.
// a single output register separates the channels: while it holds an untaken
// result and rsp_chan.ready is low, req_chan.ready is low; when the receiver
// takes the result, a new octet is accepted in the same cycle.
// reset (synchronous, active high) empties the output register and rearms the
// scanner for the start of a line; the scanner also rearms after every line.
module imap_uid_token_scanner_core
   import iuts_pkg::*;
   #(
      parameter int NUMBER_BITS = NUMBER_BITS_DEF
   )
   (
      input  logic      clock,
      input  logic      reset,
      iuts_req_if.sink   req_chan,
      iuts_rsp_if.source rsp_chan
   );

   typedef enum logic [2:0] {
      PH_SCAN,
      PH_U,
      PH_I,
      PH_D,
      PH_BLANK,
      PH_DIGITS
   } phase_type;

   localparam int MUL_W = NUMBER_BITS + 4;

   phase_type              phase_ff, phase_in;
   logic                   prevb_ff, prevb_in;
   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic                   match_ff, match_in;
   logic                   ended_ff, ended_in;

   logic               rsp_valid_ff;
   logic               rsp_found_ff, found_in;
   logic [VALUE_W-1:0] rsp_value_ff, value_in;

   logic [BYTE_W-1:0] c;
   logic              is_upper, is_lower, is_digit, is_blank, is_bnd;
   logic [BYTE_W-1:0] folded;
   logic              accept;
   phase_type         scan_next;
   logic [MUL_W-1:0]  acc_ext, mul10;
   logic              ovf;

   // handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // character classes
   assign c        = req_chan.data_byte;
   assign is_upper = (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
   assign is_lower = (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);
   assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
   assign is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
   assign is_bnd   = !(is_upper || is_lower || is_digit ||
                       (c == CHAR_DASH) || (c == CHAR_DOT) || (c == CHAR_UNDER));
   assign folded   = is_upper ? (c | 8'h20) : c;

   // restart point when a candidate breaks
   assign scan_next = ((folded == CHAR_LO_U) && prevb_ff) ? PH_U : PH_SCAN;

   // accumulate times ten plus digit, overflow past NUMBER_BITS rejects
   assign acc_ext = MUL_W'(acc_ff);
   assign mul10   = (acc_ext << 3) + (acc_ext << 1) + MUL_W'(c[3:0]);
   assign ovf     = |mul10[MUL_W-1:NUMBER_BITS];

   // next scan state for one octet
   always_comb begin
      phase_in = phase_ff;
      prevb_in = prevb_ff;
      acc_in   = acc_ff;
      match_in = match_ff;
      ended_in = ended_ff;
      if (!match_ff && !ended_ff) begin
         if (c == CHAR_NUL) begin
            if (phase_ff == PH_DIGITS) begin
               match_in = 1'b1;
            end
            ended_in = 1'b1;
         end else begin
            case (phase_ff)
               PH_U: begin
                  phase_in = (folded == CHAR_LO_I) ? PH_I : scan_next;
               end
               PH_I: begin
                  phase_in = (folded == CHAR_LO_D) ? PH_D : scan_next;
               end
               PH_D: begin
                  phase_in = is_blank ? PH_BLANK : scan_next;
               end
               PH_BLANK: begin
                  if (is_blank) begin
                     phase_in = PH_BLANK;
                  end else if (is_digit) begin
                     acc_in   = NUMBER_BITS'(c[3:0]);
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = scan_next;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) begin
                     if (ovf) begin
                        phase_in = scan_next;
                     end else begin
                        acc_in = mul10[NUMBER_BITS-1:0];
                     end
                  end else if (is_bnd) begin
                     match_in = 1'b1;
                  end else begin
                     phase_in = scan_next;
                  end
               end
               default: begin
                  phase_in = scan_next;
               end
            endcase
            prevb_in = is_bnd;
         end
      end
   end

   // result of the line, end of line closes digits in progress
   assign found_in = match_in || (!ended_in && (phase_in == PH_DIGITS));
   assign value_in = found_in ? VALUE_W'(acc_in) : '0;

   // scan state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SCAN;
         prevb_ff     <= 1'b1;
         acc_ff       <= '0;
         match_ff     <= 1'b0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (req_chan.last_byte) begin
               phase_ff     <= PH_SCAN;
               prevb_ff     <= 1'b1;
               acc_ff       <= '0;
               match_ff     <= 1'b0;
               ended_ff     <= 1'b0;
               rsp_valid_ff <= 1'b1;
               rsp_found_ff <= found_in;
               rsp_value_ff <= value_in;
            end else begin
               phase_ff <= phase_in;
               prevb_ff <= prevb_in;
               acc_ff   <= acc_in;
               match_ff <= match_in;
               ended_ff <= ended_in;
            end
         end
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.uid_found = rsp_found_ff;
   assign rsp_chan.uid_value = rsp_value_ff;

endmodule

// ===== dv/tb_imap_uid_token_scanner_core.sv =====
module tb_imap_uid_token_scanner_core
   import iuts_pkg::*;
   ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          NUM_BITS       = NUMBER_BITS_DEF;
   localparam logic [63:0] ACCUM_MAX      = {64{1'b1}} >> (64 - NUM_BITS);
   localparam int          IDLE_PCT       = 9;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          WATCHDOG_LIMIT = 2000;

   typedef enum logic [2:0] {
      ST_SCAN, ST_GOT_U, ST_GOT_UI, ST_GOT_UID, ST_BLANKS, ST_DIGITS
   } scan_state_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] value;
   } uid_result_type;

   logic clock;
   logic reset;

   iuts_req_if req_chan ();
   iuts_rsp_if rsp_chan ();

   imap_uid_token_scanner_core #(
      .NUMBER_BITS (NUM_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // scanner state as predicted
   scan_state_type scan_st;
   logic           prev_boundary;
   logic [63:0]    uid_accum;
   logic           uid_latched;
   logic           nul_seen;

   uid_result_type uid_result_q[$];
   logic [7:0]     line_octets[$];
   int             errors;
   int             stall_cycles;
   bit             idle_on;
   bit             hold_rsp;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [7:0] fold_case(logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + 8'h20 : c;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= CHAR_0 && c <= CHAR_9;
   endfunction

   function automatic logic is_word_octet(logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LO_A && c <= CHAR_LO_Z) ||
             is_digit(c) || c == CHAR_DASH || c == CHAR_DOT || c == CHAR_UNDER;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB;
   endfunction

   // the octet that broke a candidate may open a new one
   function automatic scan_state_type restart_scan(logic [7:0] c, logic prev);
      return (fold_case(c) == CHAR_LO_U && prev) ? ST_GOT_U : ST_SCAN;
   endfunction

   task automatic rearm_scan();
      scan_st       = ST_SCAN;
      prev_boundary = 1'b1;
      uid_accum     = '0;
      uid_latched   = 1'b0;
      nul_seen      = 1'b0;
   endtask

   // advance the predicted scan by one accepted octet
   task automatic scan_uid_octet(input logic [7:0] c, input logic last);
      logic           prev;
      logic [63:0]    digit;
      uid_result_type res;
      prev  = prev_boundary;
      digit = 64'(c - CHAR_0);
      if (!uid_latched && !nul_seen) begin
         if (c == CHAR_NUL) begin
            if (scan_st == ST_DIGITS) uid_latched = 1'b1;
            nul_seen = 1'b1;
         end else begin
            case (scan_st)
               ST_GOT_U: begin
                  scan_st = (fold_case(c) == CHAR_LO_I) ? ST_GOT_UI : restart_scan(c, prev);
               end
               ST_GOT_UI: begin
                  scan_st = (fold_case(c) == CHAR_LO_D) ? ST_GOT_UID : restart_scan(c, prev);
               end
               ST_GOT_UID: begin
                  scan_st = is_blank(c) ? ST_BLANKS : restart_scan(c, prev);
               end
               ST_BLANKS: begin
                  if (is_digit(c)) begin
                     if (digit > ACCUM_MAX) begin
                        scan_st = restart_scan(c, prev);
                     end else begin
                        uid_accum = digit;
                        scan_st   = ST_DIGITS;
                     end
                  end else if (!is_blank(c)) begin
                     scan_st = restart_scan(c, prev);
                  end
               end
               ST_DIGITS: begin
                  if (is_digit(c)) begin
                     // overflow drops the candidate
                     if (uid_accum > (ACCUM_MAX - digit) / 10) begin
                        scan_st = restart_scan(c, prev);
                     end else begin
                        uid_accum = uid_accum * 10 + digit;
                     end
                  end else if (!is_word_octet(c)) begin
                     uid_latched = 1'b1;
                  end else begin
                     scan_st = restart_scan(c, prev);
                  end
               end
               default: begin
                  scan_st = restart_scan(c, prev);
               end
            endcase
            prev_boundary = !is_word_octet(c);
         end
      end
      if (last) begin
         // end of line terminates digits in progress
         if (!uid_latched && !nul_seen && scan_st == ST_DIGITS) uid_latched = 1'b1;
         res.found = uid_latched;
         res.value = uid_latched ? uid_accum[VALUE_W-1:0] : '0;
         uid_result_q.push_back(res);
         rearm_scan();
      end
   endtask

   // drive one octet and wait until it is taken
   task automatic send_octet(input logic [7:0] c, input logic last);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.data_byte = c;
      req_chan.last_byte = last;
      do @(posedge clock); while (!req_chan.ready);
      scan_uid_octet(c, last);
   endtask

   task automatic send_line();
      for (int i = 0; i < line_octets.size(); i++) begin
         send_octet(line_octets[i], i == line_octets.size() - 1);
      end
   endtask

   // stop offering and wait for every pending result
   task automatic pause_until_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (uid_result_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_octets.push_back(s[i]);
   endtask

   // lowercase letters of s, each in random case
   task automatic push_mixed_case(input string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if ($urandom_range(0, 1)) c = c - 8'h20;
         line_octets.push_back(c);
      end
   endtask

   task automatic push_blank();
      line_octets.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endtask

   // mostly well-formed lines: prefix words, token, blanks, number, terminator
   task automatic make_uid_line();
      int              pick;
      bit              has_number;
      longint unsigned num;
      line_octets.delete();
      repeat ($urandom_range(0, 3)) begin
         pick = $urandom_range(0, 3);
         case (pick)
            0:       push_text("FETCH");
            1:       push_text("* 12");
            2:       line_octets.push_back(8'($urandom_range(1, 255)));
            default: push_text("x.y");
         endcase
         pick = $urandom_range(0, 7);
         case (pick)
            0:       line_octets.push_back(8'h28);
            1:       line_octets.push_back(CHAR_TAB);
            2:       ;
            default: line_octets.push_back(CHAR_SPACE);
         endcase
      end
      // token, sometimes broken
      pick = $urandom_range(0, 9);
      case (pick)
         0:       push_mixed_case("ui");
         1:       push_mixed_case("uidx");
         2:       push_mixed_case("uuid");
         default: push_mixed_case("uid");
      endcase
      if ($urandom_range(0, 5) != 0) repeat ($urandom_range(1, 3)) push_blank();
      // number, near and past the accumulator limit too
      has_number = 1'b1;
      pick = $urandom_range(0, 7);
      case (pick)
         0, 1:    num = $urandom_range(0, 999);
         2:       num = $urandom;
         3:       num = 64'hFFFF_FFFF;
         4:       num = 64'h1_0000_0000 + $urandom_range(0, 9);
         5:       num = {$urandom, $urandom};
         6:       num = {64{1'b1}};
         default: has_number = 1'b0;
      endcase
      if (has_number) push_text($sformatf("%0d", num));
      pick = $urandom_range(0, 7);
      case (pick)
         0, 1:    ;
         2:       line_octets.push_back(CHAR_SPACE);
         3:       line_octets.push_back(8'h29);
         4:       line_octets.push_back(CHAR_NUL);
         5:       line_octets.push_back(8'h78);
         6:       line_octets.push_back(CHAR_DOT);
         default: line_octets.push_back(8'h0d);
      endcase
      // trailing matter, possibly a second token
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
         push_text(" ");
         push_mixed_case("uid");
         push_blank();
         push_text($sformatf("%0d", $urandom_range(0, 99999)));
      end else if (pick == 1) begin
         repeat ($urandom_range(1, 4)) line_octets.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // raw bytes over the full range
   task automatic make_noise_line(input int max_len);
      line_octets.delete();
      repeat ($urandom_range(1, max_len)) line_octets.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_lines(input int n_octets);
      int sent;
      sent = 0;
      while (sent < n_octets) begin
         if ($urandom_range(0, 4) == 0) make_noise_line(12);
         else make_uid_line();
         send_line();
         sent += line_octets.size();
      end
   endtask

   // case folding, tabs, candidate break, zero octet, byte extremes, max value
   task automatic test_directed_lines();
      line_octets.delete();
      push_text("uId\t9");
      send_line();
      line_octets.delete();
      push_text("UID UID 7");
      line_octets.push_back(CHAR_NUL);
      push_text("U");
      send_line();
      line_octets.delete();
      line_octets.push_back(8'hFF);
      send_line();
      line_octets.delete();
      line_octets.push_back(CHAR_NUL);
      send_line();
      line_octets.delete();
      push_text("UID 4294967295");
      send_line();
   endtask

   task automatic test_burst_no_idle(input int n_octets);
      idle_on = 1'b0;
      send_random_lines(n_octets);
      idle_on = 1'b1;
   endtask

   // receiver holds off while short lines keep coming, then sender drains
   task automatic test_result_hold_off();
      hold_rsp = 1'b1;
      repeat (20) begin
         make_noise_line(3);
         send_line();
      end
      pause_until_drained();
   endtask

   task automatic test_random_lines(input int n_octets);
      send_random_lines(n_octets);
   endtask

   // receiver with random stalls and one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_chan.ready = !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // compare each result item with the oldest prediction
   always @(posedge clock) begin
      uid_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (uid_result_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected item found=%0b value=%0d", $time,
                     rsp_chan.uid_found, rsp_chan.uid_value);
         end else begin
            want = uid_result_q.pop_front();
            if (rsp_chan.uid_found !== want.found) begin
               errors++;
               $display("%0t: uid_found expected %0b actual %0b", $time,
                        want.found, rsp_chan.uid_found);
            end
            if (rsp_chan.uid_value !== want.value) begin
               errors++;
               $display("%0t: uid_value expected %0d actual %0d", $time,
                        want.value, rsp_chan.uid_value);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // test sequence
   initial begin
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      reset              = 1'b1;
      idle_on            = 1'b1;
      hold_rsp           = 1'b0;
      errors             = 0;
      stall_cycles       = 0;
      rearm_scan();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_lines();
      test_burst_no_idle(150);
      test_result_hold_off();
      test_random_lines(400);

      pause_until_drained();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/iuts_pkg.sv
rtl/core/iuts_req_if.sv
rtl/core/iuts_rsp_if.sv
rtl/core/imap_uid_token_scanner_core.sv
dv/tb_imap_uid_token_scanner_core.sv
